FILE: hw/rtl/sec2cal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sec2cal_pkg
// Shared constants and tables for the seconds-to-calendar pipeline.
// ----------------------------------------------------------------------------
package sec2cal_pkg;

	// Cycles from the accepting edge to the edge that ends the strobe cycle.
	localparam int unsigned LATENCY = 7;

	// Reciprocals for division by constants: q = (x * RECIP) >> SHIFT.
	localparam logic [31:0] RECIP_DIV60  = 32'h8888_8889; // shift 37, x < 2^32
	localparam logic [17:0] RECIP_DIV3   = 18'd174763;    // shift 19, x < 2^18
	localparam logic [16:0] RECIP_DIV7   = 17'd74899;     // shift 19, x < 2^16
	localparam logic [15:0] RECIP_DIV1461 = 16'd45934;    // shift 26, x < 2^16

	localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
	localparam logic [4:0]  HOURS_PER_DAY  = 5'd24;
	localparam logic [2:0]  DAYS_PER_WEEK  = 3'd7;
	localparam logic [10:0] DAYS_PER_GROUP = 11'd1461;
	localparam logic [15:0] EPOCH_WEEKDAY  = 16'd6;       // the epoch day was a Saturday

	// Day within a four-year group at which each year of the group starts.
	localparam logic [10:0] YEAR1_START = 11'd366;
	localparam logic [10:0] YEAR2_START = 11'd731;
	localparam logic [10:0] YEAR3_START = 11'd1096;

	localparam logic [1:0] LEAP_MASK = 2'h3;

	// Day of year on which a month starts; idx 0 is January.
	function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
		logic [8:0] base;
		begin
			case (idx)
				4'd0:    base = 9'd0;
				4'd1:    base = 9'd31;
				4'd2:    base = 9'd59;
				4'd3:    base = 9'd90;
				4'd4:    base = 9'd120;
				4'd5:    base = 9'd151;
				4'd6:    base = 9'd181;
				4'd7:    base = 9'd212;
				4'd8:    base = 9'd243;
				4'd9:    base = 9'd273;
				4'd10:   base = 9'd304;
				4'd11:   base = 9'd334;
				default: base = 9'd0;
			endcase
			// February carries the extra day, so shift every later month.
			if (leap && (idx >= 4'd2)) begin
				base = base + 9'd1;
			end
			return base;
		end
	endfunction

endpackage

FILE: hw/rtl/seconds_to_calendar_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seconds_to_calendar_core
// Splits a 32-bit count of seconds since 2000-01-01 00:00:00 into time of
// day, weekday and calendar date.
// ----------------------------------------------------------------------------
// done is the stage-7 valid bit; an accepted item passes through stages 1 to 7 in order.
// Throughput: one item per cycle; seven register stages, each holding about
//   one constant-reciprocal multiply or one compare/subtract step.
// busy stays low: the pipeline never stalls, since results cannot be held off.
// Reset clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
module seconds_to_calendar_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] seconds_count,
	output logic        done,
	output logic [5:0]  second_of_minute,
	output logic [5:0]  minute_of_hour,
	output logic [4:0]  hour_of_day,
	output logic [2:0]  weekday,
	output logic [7:0]  year_offset,
	output logic [3:0]  month_number,
	output logic [4:0]  day_of_month
);
	import sec2cal_pkg::*;

	// Valid bits travel alongside the data through every stage.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// Stage 1: total minutes.
	logic [63:0] mins_prod;
	logic [26:0] mins_s1;
	logic [5:0]  tlo_s1;

	// Stage 2: second field and total hours.
	logic [58:0] hours_prod;
	logic [11:0] sec_prod;
	logic [5:0]  sec_s2;
	logic [20:0] hours_s2;
	logic [5:0]  mlo_s2;

	// Stage 3: minute field and total days.
	logic [35:0] days_prod;
	logic [11:0] min_prod;
	logic [5:0]  sec_s3, min_s3;
	logic [15:0] days_s3;
	logic [4:0]  hlo_s3;

	// Stage 4: hour field, weekday quotient, four-year groups.
	logic [9:0]  hour_prod;
	logic [15:0] days_wk;
	logic [32:0] wk_prod;
	logic [31:0] grp_prod;
	logic [5:0]  sec_s4, min_s4;
	logic [4:0]  hour_s4;
	logic [2:0]  wklo_s4, q7lo_s4;
	logic [5:0]  groups_s4;
	logic [10:0] dlo_s4;

	// Stage 5: weekday and day within the group.
	logic [5:0]  wk_mul;
	logic [16:0] grp_days;
	logic [5:0]  sec_s5, min_s5;
	logic [4:0]  hour_s5;
	logic [2:0]  wday_s5;
	logic [5:0]  groups_s5;
	logic [10:0] rem_s5;

	// Stage 6: year and day within the year.
	logic [1:0]  yig;
	logic [10:0] year_base;
	logic [5:0]  sec_s6, min_s6;
	logic [4:0]  hour_s6;
	logic [2:0]  wday_s6;
	logic [7:0]  year_s6;
	logic [8:0]  doy_s6;
	logic        leap_s6;

	// Stage 7: month and day of month.
	logic [3:0]  mon_idx;
	logic [8:0]  mon_base;
	logic [8:0]  dom_wide;
	logic [5:0]  sec_s7, min_s7;
	logic [4:0]  hour_s7;
	logic [2:0]  wday_s7;
	logic [7:0]  year_s7;
	logic [3:0]  month_s7;
	logic [4:0]  dom_s7;

	assign busy = 1'b0;

	// Advance the valid bits every cycle; nothing ever waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage 1: minutes = seconds / 60 by reciprocal multiply.
	assign mins_prod = 64'(seconds_count) * 64'(RECIP_DIV60);

	always_ff @(posedge clk) begin
		mins_s1 <= mins_prod[63:37];
		tlo_s1  <= seconds_count[5:0];
	end

	// Stage 2: seconds field from the low bits only (the remainder is below 64);
	// hours = minutes / 60 with the same reciprocal.
	assign sec_prod   = 12'(mins_s1[5:0]) * 12'(SECS_PER_MIN);
	assign hours_prod = 59'(mins_s1) * 59'(RECIP_DIV60);

	always_ff @(posedge clk) begin
		sec_s2   <= tlo_s1 - sec_prod[5:0];
		hours_s2 <= hours_prod[57:37];
		mlo_s2   <= mins_s1[5:0];
	end

	// Stage 3: minutes field; days = (hours / 8) / 3.
	assign min_prod  = 12'(hours_s2[5:0]) * 12'(SECS_PER_MIN);
	assign days_prod = 36'(hours_s2[20:3]) * 36'(RECIP_DIV3);

	always_ff @(posedge clk) begin
		sec_s3  <= sec_s2;
		min_s3  <= mlo_s2 - min_prod[5:0];
		days_s3 <= days_prod[34:19];
		hlo_s3  <= hours_s2[4:0];
	end

	// Stage 4: hours field; quotient for the weekday; count four-year groups.
	assign hour_prod = 10'(days_s3[4:0]) * 10'(HOURS_PER_DAY);
	assign days_wk   = days_s3 + EPOCH_WEEKDAY;
	assign wk_prod   = 33'(days_wk) * 33'(RECIP_DIV7);
	assign grp_prod  = 32'(days_s3) * 32'(RECIP_DIV1461);

	always_ff @(posedge clk) begin
		sec_s4    <= sec_s3;
		min_s4    <= min_s3;
		hour_s4   <= hlo_s3 - hour_prod[4:0];
		wklo_s4   <= days_wk[2:0];
		q7lo_s4   <= wk_prod[21:19];
		groups_s4 <= grp_prod[31:26];
		dlo_s4    <= days_s3[10:0];
	end

	// Stage 5: weekday and day within the group, both from low bits only.
	assign wk_mul   = 6'(q7lo_s4) * 6'(DAYS_PER_WEEK);
	assign grp_days = 17'(groups_s4) * 17'(DAYS_PER_GROUP);

	always_ff @(posedge clk) begin
		sec_s5    <= sec_s4;
		min_s5    <= min_s4;
		hour_s5   <= hour_s4;
		wday_s5   <= wklo_s4 - wk_mul[2:0];
		groups_s5 <= groups_s4;
		rem_s5    <= dlo_s4 - grp_days[10:0];
	end

	// Stage 6: pick the year within the group; the first year of a group is leap.
	always_comb begin
		if (rem_s5 >= YEAR3_START) begin
			yig       = 2'd3;
			year_base = YEAR3_START;
		end else if (rem_s5 >= YEAR2_START) begin
			yig       = 2'd2;
			year_base = YEAR2_START;
		end else if (rem_s5 >= YEAR1_START) begin
			yig       = 2'd1;
			year_base = YEAR1_START;
		end else begin
			yig       = 2'd0;
			year_base = 11'd0;
		end
	end

	always_ff @(posedge clk) begin
		sec_s6  <= sec_s5;
		min_s6  <= min_s5;
		hour_s6 <= hour_s5;
		wday_s6 <= wday_s5;
		year_s6 <= {groups_s5, yig};
		doy_s6  <= 9'(rem_s5 - year_base);
		leap_s6 <= (yig & LEAP_MASK) == 2'd0;
	end

	// Stage 7: count the months whose start the day of year has reached.
	always_comb begin
		mon_idx = 4'd0;
		for (int k = 1; k < 12; k++) begin
			if (doy_s6 >= month_start(4'(k), leap_s6)) begin
				mon_idx = mon_idx + 4'd1;
			end
		end
		mon_base = month_start(mon_idx, leap_s6);
		dom_wide = doy_s6 - mon_base + 9'd1;
	end

	always_ff @(posedge clk) begin
		sec_s7   <= sec_s6;
		min_s7   <= min_s6;
		hour_s7  <= hour_s6;
		wday_s7  <= wday_s6;
		year_s7  <= year_s6;
		month_s7 <= mon_idx + 4'd1;
		dom_s7   <= dom_wide[4:0];
	end

	// Drive the result ports straight from the last stage.
	assign done             = v_s7;
	assign second_of_minute = sec_s7;
	assign minute_of_hour   = min_s7;
	assign hour_of_day      = hour_s7;
	assign weekday          = wday_s7;
	assign year_offset      = year_s7;
	assign month_number     = month_s7;
	assign day_of_month     = dom_s7;

endmodule

FILE: hw/rtl/sec2cal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sec2cal_checker
// Port-level checks for the seconds-to-calendar core, bound into the core module.
// ----------------------------------------------------------------------------
module sec2cal_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [5:0] second_of_minute,
	input logic [5:0] minute_of_hour,
	input logic [4:0] hour_of_day,
	input logic [2:0] weekday,
	input logic [7:0] year_offset,
	input logic [3:0] month_number,
	input logic [4:0] day_of_month
);
	import sec2cal_pkg::*;

	// Every accepted item yields a strobe a fixed number of cycles later.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted item produced no result");

	// No strobe without an item accepted the same distance back.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LATENCY !done)
		else $error("result strobe without an accepted item");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (second_of_minute < 6'd60) && (minute_of_hour < 6'd60) &&
			(hour_of_day < 5'd24) && (weekday < 3'd7))
		else $error("time of day or weekday out of range");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (year_offset <= 8'd136) && (month_number >= 4'd1) &&
			(month_number <= 4'd12) && (day_of_month >= 5'd1))
		else $error("date field out of range");

endmodule

bind seconds_to_calendar_core sec2cal_checker u_sec2cal_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.second_of_minute (second_of_minute),
	.minute_of_hour   (minute_of_hour),
	.hour_of_day      (hour_of_day),
	.weekday          (weekday),
	.year_offset      (year_offset),
	.month_number     (month_number),
	.day_of_month     (day_of_month)
);
